[rtl/core/lsbse_pkg.sv]
package lsbse_pkg;

    localparam int POS_W  = 36;
    localparam int CH_W   = 8;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 1;

    localparam logic [CIDX_W-1:0] REG_MODE    = 1'b0;
    localparam logic [CIDX_W-1:0] REG_MSG_LEN = 1'b1;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [CFG_W-1:0] message_length;
    } cfg_t;

    typedef struct packed {
        logic            frame_start;
        logic [CH_W-1:0] channel_in;
        logic [CH_W-1:0] message_byte;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] channel_out;
        logic [CH_W-1:0] text_byte;
        logic            text_valid;
        logic            message_done;
    } result_t;

endpackage

[rtl/core/lsbse_datapath.sv]
module lsbse_datapath #(
    parameter int HEADER_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  lsbse_pkg::cfg_t   cfg,
    input  lsbse_pkg::item_t  item,
    output lsbse_pkg::result_t result
);

    localparam int HB     = HEADER_BITS;
    localparam int IDX_W  = $clog2(HB);
    localparam int SPAN_W = HB + 3;
    localparam int POS_W  = lsbse_pkg::POS_W;
    localparam int CMP_W  = POS_W + 1;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [HB-1:0]    hdr_reg,  hdr_next;
    logic [7:0]       byte_reg, byte_next;
    logic [HB-1:0]    flen_reg, flen_next;

    logic [POS_W-1:0]  pos;
    logic [HB-1:0]     hdr_cur;
    logic [7:0]        byte_cur;
    logic [HB-1:0]     flen_cur;
    logic              in_hdr;
    logic [POS_W-1:0]  rel;
    logic [HB-1:0]     len;
    logic [SPAN_W-1:0] span_e;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_n;
    logic              in_msg_e;
    logic              in_msg_x;
    logic [IDX_W-1:0]  hidx;
    logic              hdr_bit;
    logic              msg_bit;
    logic              emb_bit;
    logic [CMP_W-1:0]  p1;
    logic              done_e;
    logic              done_x;
    logic              lsb;
    logic [HB-1:0]     hdr_shifted;
    logic [7:0]        byte_shifted;
    logic              last_hdr;
    logic [HB-1:0]     flen_new;

    always_comb begin
        pos      = item.frame_start ? '0 : pos_reg;
        hdr_cur  = item.frame_start ? '0 : hdr_reg;
        byte_cur = item.frame_start ? '0 : byte_reg;
        flen_cur = item.frame_start ? '0 : flen_reg;

        in_hdr = pos < POS_W'(HB);
        rel    = pos - POS_W'(HB);
        p1     = {1'b0, pos} + CMP_W'(1);

        len      = cfg.message_length[HB-1:0];
        span_e   = {len, 3'b000};
        in_msg_e = !in_hdr && (rel < POS_W'(span_e));
        hidx     = IDX_W'(HB - 1) - pos[IDX_W-1:0];
        hdr_bit  = len[hidx];
        msg_bit  = item.message_byte[3'd7 - rel[2:0]];
        emb_bit  = in_hdr ? hdr_bit : msg_bit;
        done_e   = p1 >= (CMP_W'(HB) + CMP_W'(span_e));

        lsb          = item.channel_in[0];
        hdr_shifted  = {hdr_cur[HB-2:0], lsb};
        byte_shifted = {byte_cur[6:0], lsb};
        last_hdr     = pos == POS_W'(HB - 1);
        span_x       = {flen_cur, 3'b000};
        in_msg_x     = !in_hdr && (rel < POS_W'(span_x));
        flen_new     = (in_hdr && last_hdr) ? hdr_shifted : flen_cur;
        span_n       = {flen_new, 3'b000};
        done_x       = (p1 >= CMP_W'(HB)) && (p1 >= (CMP_W'(HB) + CMP_W'(span_n)));

        pos_next  = (pos != '1) ? pos + POS_W'(1) : pos;
        hdr_next  = hdr_cur;
        byte_next = byte_cur;
        flen_next = flen_cur;

        result.channel_out  = item.channel_in;
        result.text_byte    = '0;
        result.text_valid   = 1'b0;
        result.message_done = done_e;

        if (cfg.mode == lsbse_pkg::MODE_EMBED) begin
            if (in_hdr || in_msg_e) begin
                result.channel_out = {item.channel_in[7:1], emb_bit};
            end
        end else begin
            result.message_done = done_x;
            flen_next           = flen_new;
            if (in_hdr) begin
                hdr_next = hdr_shifted;
            end else if (in_msg_x) begin
                byte_next = byte_shifted;
                if (rel[2:0] == 3'd7) begin
                    result.text_byte  = byte_shifted;
                    result.text_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            byte_reg <= '0;
            flen_reg <= '0;
        end else if (fire) begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            byte_reg <= byte_next;
            flen_reg <= flen_next;
        end
    end

endmodule

[rtl/core/lsb_stego_embed_extract.sv]
// LSB steganography embedder / extractor for a stream of color channel bytes.
// Input channel (s_*): one channel byte per transaction in raster order with
// channels interleaved; s_tuser flags the first byte of an image, which
// restarts the byte position and clears the gathered length and byte.
// Output channel (m_*): exactly one transaction per input transaction, in order.
// Embed mode (mode register 0): the first HEADER_BITS bytes carry the length
// register MSB first in their LSBs, the next length*8 bytes carry the message
// bits MSB first (message_byte held for its eight bytes), later bytes pass.
// Extract mode (mode register 1): bytes pass unchanged; every completed
// message byte appears in text_byte with text_valid set.
// message_done rises once header and message bits have all been handled.
// A transaction passes through the input register, then the result register,
// before it is offered on m_*. Throughput: one transaction per cycle while
// m_tready does not stall, with the position/shift state updated per transfer.
// A stall on m_tready holds the result register; if the input register is empty,
// one more transaction is taken into it before s_tready drops. Reset clears the
// position, shift registers, configuration and both valid flags. The user must
// write configuration through cfg_* only while the stream is idle (not enforced).
module lsb_stego_embed_extract #(
    parameter int HEADER_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [lsbse_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [lsbse_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // channel_in, message_byte
    input  logic [0:0]                          s_tuser,  // frame_start

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // channel_out, text_byte
    output logic [1:0]                          m_tuser   // text_valid, message_done
);

    lsbse_pkg::cfg_t    cfg_reg;
    lsbse_pkg::item_t   in_reg;
    logic               in_valid_reg;
    lsbse_pkg::result_t out_reg;
    logic               out_valid_reg;
    lsbse_pkg::result_t result;
    logic               advance;
    logic               fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode           <= lsbse_pkg::MODE_EMBED;
            cfg_reg.message_length <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsbse_pkg::REG_MODE:    cfg_reg.mode           <= cfg_wdata[0];
                lsbse_pkg::REG_MSG_LEN: cfg_reg.message_length <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.frame_start  <= s_tuser[0];
            in_reg.channel_in   <= s_tdata[7:0];
            in_reg.message_byte <= s_tdata[15:8];
        end
    end

    lsbse_datapath #(
        .HEADER_BITS(HEADER_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.text_byte, out_reg.channel_out};
    assign m_tuser  = {out_reg.message_done, out_reg.text_valid};

endmodule
